// ----- rtl/sdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants of the shaded disc frame store.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int CFG_W    = 7;
  localparam int POS_W    = 12;
  localparam int RAD_W    = 6;
  localparam int COLOR_W  = 32;
  localparam int DATA_W   = 64;
  localparam int OFS_W    = 8;
  localparam int D2_W     = 12;
  localparam int NUM_W    = 36;
  localparam int ROOT_W   = 18;
  localparam int REM_W    = 20;
  localparam int Q_W      = 13;
  localparam int SHADE_W  = 13;
  localparam int CALC_W   = 14;

  localparam logic [CFG_W-1:0]   FRAME_RESET = 7'd64;
  localparam logic [4:0]         STEP_LAST   = 5'd17;
  localparam logic [SHADE_W-1:0] SHADE_ONE   = 13'd4096;
  localparam logic [10:0]        SHADE_K     = 11'd1229;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [4:0] {
    SH_IDLE = 5'b00001,
    SH_SQRT = 5'b00010,
    SH_DIV  = 5'b00100,
    SH_SCL  = 5'b01000,
    SH_MIX  = 5'b10000
  } shade_state_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_SHADE = 6'b001000,
    ST_READ  = 6'b010000,
    ST_RDATA = 6'b100000
  } ctrl_state_t;

  typedef struct packed {
    logic                    start;
    logic [D2_W-1:0]         d2;
    logic [RAD_W-1:0]        radius;
    logic [23:0]             color;
  } shade_req_t;

  typedef struct packed {
    logic                    done;
    logic [COLOR_W-1:0]      pixel;
  } shade_rsp_t;

endpackage

// ----- rtl/sdf_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_store
// Frame memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdf_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [sdf_pkg::COLOR_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [sdf_pkg::COLOR_W-1:0] rdata
);
  import sdf_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sdf_shade.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_shade
// Per-pixel shading unit: bit-serial square root, bit-serial divide by the
// radius, then the falloff multiply and the three channel scales.
// ----------------------------------------------------------------------------
module sdf_shade (
  input  logic                clk,
  input  logic                rst_n,
  input  sdf_pkg::shade_req_t req,
  output sdf_pkg::shade_rsp_t rsp
);
  import sdf_pkg::*;

  shade_state_t          st_r, st_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic [RAD_W-1:0]      drem_r, drem_nxt;
  logic [RAD_W-1:0]      rad_r;
  logic [23:0]           col_r;
  logic [SHADE_W-1:0]    shade_r, shade_nxt;
  logic [COLOR_W-1:0]    pix_r, pix_nxt;
  logic                  done_r, done_nxt;

  logic [REM_W+1:0]      rem_sh, trial;
  logic [RAD_W:0]        dtrial;
  logic [23:0]           kprod;
  logic [20:0]           pr, pg, pb;

  always_comb begin
    rem_sh    = {rem_r, num_r[NUM_W-1 -: 2]};
    trial     = {2'b00, root_r, 2'b01};
    dtrial    = {drem_r, root_r[ROOT_W-1]};
    kprod     = 24'(root_r[Q_W-1:0] * SHADE_K);
    pr        = 21'(col_r[23:16] * shade_r);
    pg        = 21'(col_r[15:8] * shade_r);
    pb        = 21'(col_r[7:0] * shade_r);

    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    drem_nxt  = drem_r;
    shade_nxt = shade_r;
    pix_nxt   = pix_r;
    done_nxt  = 1'b0;

    unique case (st_r)
      SH_IDLE: begin
        if (req.start) begin
          num_nxt  = {req.d2, 24'd0};
          rem_nxt  = '0;
          root_nxt = '0;
          cnt_nxt  = '0;
          st_nxt   = SH_SQRT;
        end
      end
      SH_SQRT: begin
        num_nxt = {num_r[NUM_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = REM_W'(rem_sh - trial);
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = REM_W'(rem_sh);
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == STEP_LAST) begin
          cnt_nxt  = '0;
          drem_nxt = '0;
          st_nxt   = SH_DIV;
        end
      end
      SH_DIV: begin
        if (dtrial >= {1'b0, rad_r}) begin
          drem_nxt = RAD_W'(dtrial - {1'b0, rad_r});
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          drem_nxt = dtrial[RAD_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == STEP_LAST) begin
          if (rad_r == '0) begin
            root_nxt = '0;
          end
          st_nxt = SH_SCL;
        end
      end
      SH_SCL: begin
        shade_nxt = SHADE_ONE - SHADE_W'(kprod >> 12);
        st_nxt    = SH_MIX;
      end
      SH_MIX: begin
        pix_nxt  = {8'd0, pr[19:12], pg[19:12], pb[19:12]};
        done_nxt = 1'b1;
        st_nxt   = SH_IDLE;
      end
      default: st_nxt = SH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SH_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    drem_r  <= drem_nxt;
    shade_r <= shade_nxt;
    pix_r   <= pix_nxt;
    if (st_r == SH_IDLE && req.start) begin
      rad_r <= req.radius;
      col_r <= req.color;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.pixel = pix_r;

endmodule

// ----- rtl/shaded_disc_framebuffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shaded_disc_framebuffer
// Frame store with clear, shaded filled-disc draw and single-pixel read.
//
// Input channel in_*: one command per transaction (clear, draw, read).
// Output channel out_*: one transaction per read, none for clear or draw.
// cfg_*: frame width and height, written by the user only while the block is idle; unchecked.
// Commands run one at a time; in_tready is high only between commands.
// Clear: one memory word per cycle, over all w*h words of the frame.
// Draw: scans each candidate pixel of the (2r+1) by (2r+1) square; a painted
//   pixel holds the scan while the bit-serial square root and divide of the
//   shading unit (18 steps each), the falloff scale and the mix run.
// Read: ST_READ issues the read to the registered port of the frame memory,
//   then ST_RDATA loads the output register; off the frame ST_READ loads it.
// A finished read waits in the output register; a new command is taken
// meanwhile, but a further read holds until that result has gone.
// Reset returns width and height to 64 and empties the output register;
// the frame memory keeps no reset value and reads are defined after a clear.
// ----------------------------------------------------------------------------
module shaded_disc_framebuffer #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_RADIUS = 63
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // operation[1:0], pos_x[13:2], pos_y[25:14], radius[31:26], color[63:32]
  input  logic [sdf_pkg::DATA_W-1:0]  in_tdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // pixel_color[31:0]
  output logic [sdf_pkg::COLOR_W-1:0] out_tdata,
  // out_of_range[0]
  output logic                        out_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sdf_pkg::CFG_W-1:0]   cfg_wdata
);
  import sdf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ctrl_state_t           state_r, state_nxt;
  logic [CFG_W-1:0]      fw_r, fh_r, w_act, h_act;
  logic [POS_W-1:0]      px_r, py_r;
  logic [RAD_W-1:0]      rad_r;
  logic [COLOR_W-1:0]    col_r;
  logic signed [OFS_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [CALC_W-1:0]     clr_idx_r, clr_idx_nxt;
  logic [AW-1:0]         addr_r;
  logic                  oor_r;
  logic [COLOR_W-1:0]    out_data_r;
  logic                  out_oor_r, out_valid_r;

  logic [1:0]            in_op;
  logic [POS_W-1:0]      in_px, in_py;
  logic [RAD_W-1:0]      in_rad, rad_eff;
  logic [COLOR_W-1:0]    in_col;
  logic                  accept, slot_free, rd_oor;
  logic [CALC_W-1:0]     rd_addr, clr_last;

  logic signed [OFS_W-1:0] r8, neg_r8;
  logic [CALC_W-1:0]     d2, rr;
  logic signed [POS_W:0] xs, ys;
  logic                  on_frame, in_disc, last;
  logic [CALC_W-1:0]     pix_addr;

  logic                  mem_we, rd_en;
  logic [AW-1:0]         mem_waddr;
  logic [COLOR_W-1:0]    mem_wdata, mem_rdata;
  logic                  load_out;
  logic [COLOR_W-1:0]    load_data;
  logic                  load_oor;

  shade_req_t            sh_req;
  shade_rsp_t            sh_rsp;

  assign in_op  = in_tdata[1:0];
  assign in_px  = in_tdata[13:2];
  assign in_py  = in_tdata[25:14];
  assign in_rad = in_tdata[31:26];
  assign in_col = in_tdata[63:32];

  always_comb begin
    w_act = fw_r;
    if (fw_r == '0) w_act = 7'd1;
    else if (32'(fw_r) > MAX_WIDTH) w_act = CFG_W'(MAX_WIDTH);
    h_act = fh_r;
    if (fh_r == '0) h_act = 7'd1;
    else if (32'(fh_r) > MAX_HEIGHT) h_act = CFG_W'(MAX_HEIGHT);
    rad_eff = in_rad;
    if (32'(in_rad) > MAX_RADIUS) rad_eff = RAD_W'(MAX_RADIUS);
  end

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign rd_oor  = in_px[POS_W-1] || in_py[POS_W-1] ||
                   (in_px >= {5'd0, w_act}) || (in_py >= {5'd0, h_act});
  assign rd_addr = CALC_W'(in_py[CFG_W-1:0] * w_act) + CALC_W'(in_px[CFG_W-1:0]);
  assign clr_last = CALC_W'(w_act * h_act) - CALC_W'(1);

  assign r8     = $signed({2'b00, rad_r});
  assign neg_r8 = -r8;
  assign d2     = CALC_W'(dx_r * dx_r) + CALC_W'(dy_r * dy_r);
  assign rr     = CALC_W'(rad_r * rad_r);
  assign xs     = $signed({px_r[POS_W-1], px_r}) + POS_W'(dx_r) + 13'sd0;
  assign ys     = $signed({py_r[POS_W-1], py_r}) + POS_W'(dy_r) + 13'sd0;
  assign on_frame = !xs[POS_W] && !ys[POS_W] &&
                    (xs < $signed({6'd0, w_act})) && (ys < $signed({6'd0, h_act}));
  assign in_disc  = (d2 <= rr) && on_frame;
  assign last     = (dx_r == r8) && (dy_r == r8);
  assign pix_addr = CALC_W'(ys[CFG_W-1:0] * w_act) + CALC_W'(xs[CFG_W-1:0]);

  always_comb begin
    state_nxt   = state_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    clr_idx_nxt = clr_idx_r;
    mem_we      = 1'b0;
    mem_waddr   = addr_r;
    mem_wdata   = sh_rsp.pixel;
    rd_en       = 1'b0;
    load_out    = 1'b0;
    load_data   = mem_rdata;
    load_oor    = 1'b0;
    sh_req.start  = 1'b0;
    sh_req.d2     = D2_W'(d2);
    sh_req.radius = rad_r;
    sh_req.color  = col_r[23:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_CLEAR: begin
              clr_idx_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            OP_DRAW: begin
              dx_nxt    = -$signed({2'b00, rad_eff});
              dy_nxt    = -$signed({2'b00, rad_eff});
              state_nxt = ST_SCAN;
            end
            OP_READ: state_nxt = ST_READ;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = AW'(clr_idx_r);
        mem_wdata   = col_r;
        clr_idx_nxt = clr_idx_r + CALC_W'(1);
        if (clr_idx_r == clr_last) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (in_disc) begin
          sh_req.start = 1'b1;
          state_nxt    = ST_SHADE;
        end else if (last) begin
          state_nxt = ST_IDLE;
        end else if (dx_r == r8) begin
          dx_nxt = neg_r8;
          dy_nxt = dy_r + 8'sd1;
        end else begin
          dx_nxt = dx_r + 8'sd1;
        end
      end
      ST_SHADE: begin
        if (sh_rsp.done) begin
          mem_we = 1'b1;
          if (last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SCAN;
            if (dx_r == r8) begin
              dx_nxt = neg_r8;
              dy_nxt = dy_r + 8'sd1;
            end else begin
              dx_nxt = dx_r + 8'sd1;
            end
          end
        end
      end
      ST_READ: begin
        if (slot_free) begin
          if (oor_r) begin
            load_out  = 1'b1;
            load_data = '0;
            load_oor  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            rd_en     = 1'b1;
            state_nxt = ST_RDATA;
          end
        end
      end
      ST_RDATA: begin
        load_out  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fw_r        <= FRAME_RESET;
      fh_r        <= FRAME_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  fw_r <= cfg_wdata;
          CFG_FRAME_HEIGHT: fh_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    clr_idx_r <= clr_idx_nxt;
    if (accept) begin
      px_r   <= in_px;
      py_r   <= in_py;
      rad_r  <= rad_eff;
      col_r  <= in_col;
      oor_r  <= rd_oor;
      addr_r <= AW'(rd_addr);
    end else if (sh_req.start) begin
      addr_r <= AW'(pix_addr);
    end
    if (load_out) begin
      out_data_r <= load_data;
      out_oor_r  <= load_oor;
    end
  end

  sdf_shade u_shade (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sh_req),
    .rsp   (sh_rsp)
  );

  sdf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oor_r;
  assign out_tvalid = out_valid_r;

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_SHADE))
    else $error("frame write outside clear or shade");

  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    sh_req.start |-> (state_r == ST_SCAN))
    else $error("shade start outside scan");

  a_rd_slot: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> slot_free)
    else $error("read issued while result pending");

  a_rd_follow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == ST_RDATA && load_out))
    else $error("read data not captured");

endmodule
